// File: design/serial_frame_receiver_crc16_macros.svh
// assertion macros shared by the deframer rtl
`ifndef SERIAL_FRAME_RECEIVER_CRC16_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_CRC16_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define SFRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent holds in the cycle after
`define SFRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sfrc_pkg.sv
// types, constants and the crc step of the frame receiver
`timescale 1ns / 1ps
`default_nettype none

package sfrc_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 64;
    localparam int unsigned FRAME_OVERHEAD      = 7;
    localparam logic [7:0]  START_BYTE          = 8'h3A;
    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [15:0] CRC_POLY            = 16'h1021;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_BODY,
        PH_REPLAY
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD,
        ST_LEN_ERR,
        ST_CRC_ERR,
        ST_STRAY
    } status_t;

    // crc-16/ccitt-false, one byte, msb first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/serial_frame_receiver_crc16.sv
// byte stream deframer with crc-16 check and payload replay from a buffer
//
// rx channel: one received byte per beat (rx_valid, rx_stall, rx_byte).
// result channel: status, frame_type, payload_byte, has_byte, last per beat
// (res_valid, res_stall).
// frame: start byte 0x3A, length (le16, whole frame), type (le16), payload,
// crc (be16). crc-16/ccitt-false runs over every frame byte incl. the crc.
// one byte is taken per cycle while receiving and rx_stall is low; payload
// bytes go into a single-port-write buffer memory with a registered read.
// a stray byte, rejected length, bad crc or empty good frame gives one
// result, visible the cycle after the byte that caused it.
// a good frame with n payload bytes is replayed from the buffer, one beat
// per cycle unless res_stall holds it; after the last crc byte, the phase
// register enters replay and then the first beat loads the result register;
// rx_stall is held high throughout the replay.
// rx_stall is also high while a result waits and res_stall is high.
// reset (rst_n low, asynchronous) returns to hunting for the start byte
// and empties the result register; the buffer needs no clearing.

`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver_crc16 #(
    parameter int unsigned MAX_FRAME_BYTES = sfrc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       status,
    output logic [15:0]      frame_type,
    output logic [7:0]       payload_byte,
    output logic             has_byte,
    output logic             last
);

    import sfrc_pkg::*;

    `include "serial_frame_receiver_crc16_macros.svh"

    localparam int unsigned STORE_DEPTH = (MAX_FRAME_BYTES > FRAME_OVERHEAD + 1) ?
                                          (MAX_FRAME_BYTES - FRAME_OVERHEAD) : 1;
    localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_BYTES);
    localparam logic [15:0] MIN_LEN = 16'(FRAME_OVERHEAD);

    // control and frame state
    phase_t         phase_reg, phase_next;
    logic [6:0]     cnt_reg, cnt_next;
    logic [15:0]    len_reg, len_next;
    logic [15:0]    crc_reg, crc_next;
    logic [15:0]    type_reg, type_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [AW-1:0]  last_idx_reg, last_idx_next;

    // result register
    logic           out_valid_reg, out_valid_next;
    status_t        out_status_reg, out_status_next;
    logic [15:0]    out_type_reg, out_type_next;
    logic           out_has_reg, out_has_next;
    logic           out_last_reg, out_last_next;

    // payload buffer
    logic [7:0]     store_mem [STORE_DEPTH];
    logic [7:0]     rd_data_reg;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;

    logic           out_free;
    logic           rx_take;
    logic [15:0]    crc_step;
    logic [15:0]    len_full;
    logic           len_bad;
    logic [15:0]    pos_ext;
    logic           body_end;
    logic           body_store;
    logic           frame_empty;
    logic           replay_last;
    logic [6:0]     pos_off;

    assign out_free    = !out_valid_reg || !res_stall;
    assign rx_stall    = (phase_reg == PH_REPLAY) || !out_free;
    assign rx_take     = rx_valid && !rx_stall;
    assign crc_step    = crc16_update((phase_reg == PH_HUNT) ? CRC_INIT : crc_reg, rx_byte);
    assign len_full    = {rx_byte, len_reg[7:0]};
    assign len_bad     = (len_full < MIN_LEN) || (len_full > MAX_LEN);
    assign pos_ext     = {9'b0, cnt_reg};
    assign body_end    = (pos_ext + 16'd1) >= len_reg;
    assign body_store  = (cnt_reg != 7'd3) && (cnt_reg != 7'd4) && ((pos_ext + 16'd2) < len_reg);
    assign frame_empty = (len_reg == MIN_LEN);
    assign replay_last = (idx_reg == last_idx_reg);
    assign pos_off     = cnt_reg - 7'd5;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_take && (rx_byte == START_BYTE))
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                if (rx_take && (cnt_reg != 7'd1))
                begin
                    phase_next = len_bad ? PH_HUNT : PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (rx_take && body_end)
                begin
                    phase_next = ((crc_step == 16'h0000) && !frame_empty) ? PH_REPLAY : PH_HUNT;
                end
            end
            PH_REPLAY:
            begin
                if (out_free && replay_last)
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // datapath, buffer access and result loading
    always_comb
    begin
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        type_next       = type_reg;
        idx_next        = idx_reg;
        last_idx_next   = last_idx_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_off[AW-1:0];
        rd_en           = 1'b0;
        out_valid_next  = out_valid_reg && res_stall;
        out_status_next = out_status_reg;
        out_type_next   = out_type_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_take)
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        crc_next = crc_step;
                        cnt_next = 7'd1;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_STRAY;
                        out_type_next   = 16'h0000;
                        out_has_next    = 1'b0;
                        out_last_next   = 1'b1;
                    end
                end
            end
            PH_LENGTH:
            begin
                if (rx_take)
                begin
                    crc_next = crc_step;
                    if (cnt_reg == 7'd1)
                    begin
                        len_next = {8'h00, rx_byte};
                        cnt_next = 7'd2;
                    end
                    else if (len_bad)
                    begin
                        cnt_next        = 7'd0;
                        len_next        = 16'h0000;
                        crc_next        = CRC_INIT;
                        type_next       = 16'h0000;
                        out_valid_next  = 1'b1;
                        out_status_next = ST_LEN_ERR;
                        out_type_next   = 16'h0000;
                        out_has_next    = 1'b0;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        len_next = len_full;
                        cnt_next = 7'd3;
                    end
                end
            end
            PH_BODY:
            begin
                if (rx_take)
                begin
                    crc_next = crc_step;
                    if (cnt_reg == 7'd3)
                    begin
                        type_next = {8'h00, rx_byte};
                    end
                    else if (cnt_reg == 7'd4)
                    begin
                        type_next = {rx_byte, type_reg[7:0]};
                    end
                    else if (body_store)
                    begin
                        wr_en = 1'b1;
                    end

                    if (body_end)
                    begin
                        cnt_next      = 7'd0;
                        crc_next      = CRC_INIT;
                        idx_next      = '0;
                        last_idx_next = AW'(len_reg - MIN_LEN - 16'd1);
                        if (crc_step != 16'h0000)
                        begin
                            len_next        = 16'h0000;
                            type_next       = 16'h0000;
                            out_valid_next  = 1'b1;
                            out_status_next = ST_CRC_ERR;
                            out_type_next   = 16'h0000;
                            out_has_next    = 1'b0;
                            out_last_next   = 1'b1;
                        end
                        else if (frame_empty)
                        begin
                            len_next        = 16'h0000;
                            type_next       = 16'h0000;
                            out_valid_next  = 1'b1;
                            out_status_next = ST_GOOD;
                            out_type_next   = type_reg;
                            out_has_next    = 1'b0;
                            out_last_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 7'd1;
                    end
                end
            end
            PH_REPLAY:
            begin
                // the read data lands in rd_data_reg with the result beat
                if (out_free)
                begin
                    rd_en           = 1'b1;
                    idx_next        = idx_reg + AW'(1);
                    out_valid_next  = 1'b1;
                    out_status_next = ST_GOOD;
                    out_type_next   = type_reg;
                    out_has_next    = 1'b1;
                    out_last_next   = replay_last;
                    if (replay_last)
                    begin
                        len_next  = 16'h0000;
                        type_next = 16'h0000;
                    end
                end
            end
            default:
            begin
                cnt_next = 7'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            cnt_reg        <= 7'd0;
            len_reg        <= 16'h0000;
            crc_reg        <= CRC_INIT;
            type_reg       <= 16'h0000;
            idx_reg        <= '0;
            last_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_GOOD;
            out_type_reg   <= 16'h0000;
            out_has_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            len_reg        <= len_next;
            crc_reg        <= crc_next;
            type_reg       <= type_next;
            idx_reg        <= idx_next;
            last_idx_reg   <= last_idx_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_type_reg   <= out_type_next;
            out_has_reg    <= out_has_next;
            out_last_reg   <= out_last_next;
        end
    end

    // payload buffer, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    assign res_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign frame_type   = out_type_reg;
    assign payload_byte = out_has_reg ? rd_data_reg : 8'h00;
    assign has_byte     = out_has_reg;
    assign last         = out_last_reg;

    `SFRC_ASSERT_SAME(a_status_single, clk, rst_n, res_valid && (status != ST_GOOD), last && !has_byte && (frame_type == 16'h0000), "error result must be a single beat")
    `SFRC_ASSERT_SAME(a_empty_is_last, clk, rst_n, res_valid && (status == ST_GOOD) && !has_byte, last, "empty good frame must be last")
    `SFRC_ASSERT_SAME(a_no_write_in_replay, clk, rst_n, phase_reg == PH_REPLAY, !wr_en && rx_stall, "buffer written during replay")
    `SFRC_ASSERT_NEXT(a_replay_ends, clk, rst_n, (phase_reg == PH_REPLAY) && rd_en && replay_last, (phase_reg == PH_HUNT) && res_valid && last, "replay did not finish on last beat")

endmodule

`default_nettype wire
